[rtl/tlr_pkg.sv]
// Shared types and constants for the thick line rasteriser.
package tlr_pkg;

  localparam int COORD_BITS = 10;
  localparam int THICK_BITS = 8;
  localparam int WALK_BITS  = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;
  localparam int CFG_IDX_BITS = 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [WALK_BITS-1:0]  walk_t;
  typedef logic [THICK_BITS-1:0] thick_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_IDLE     = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 1'd0,
    CFG_SCREEN_HEIGHT = 1'd1
  } cfg_reg_t;

  localparam coord_t WIDTH_RESET  = COORD_BITS'(240);
  localparam coord_t HEIGHT_RESET = COORD_BITS'(320);

  typedef struct packed {
    kind_t  kind;
    coord_t px;
    coord_t py;
    color_t color;
    logic   last;
  } result_t;

  typedef struct packed {
    coord_t width;
    coord_t height;
  } screen_t;

endpackage

[rtl/tlr_cfg.sv]
// Screen size registers, written through the plain write port.
module tlr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [tlr_pkg::CFG_IDX_BITS-1:0] wr_index,
  input  tlr_pkg::coord_t               wr_data,
  output tlr_pkg::screen_t              screen
);
  import tlr_pkg::*;

  coord_t width_r;
  coord_t height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        CFG_SCREEN_WIDTH:  width_r  <= wr_data;
        CFG_SCREEN_HEIGHT: height_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign screen.width  = width_r;
  assign screen.height = height_r;

endmodule

[rtl/tlr_core.sv]
// Line state and single-step walk logic: one result per accepted item.
module tlr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             req_type,
  input  tlr_pkg::coord_t  x_start,
  input  tlr_pkg::coord_t  y_start,
  input  tlr_pkg::coord_t  x_end,
  input  tlr_pkg::coord_t  y_end,
  input  tlr_pkg::thick_t  thickness,
  input  tlr_pkg::color_t  pen_color,
  input  tlr_pkg::screen_t screen,
  output tlr_pkg::result_t res
);
  import tlr_pkg::*;

  logic   busy_r, busy_nxt;
  coord_t x0_r, y0_r, x1_r, y1_r;
  coord_t adx_r, ady_r, dist_r;
  logic   shx_r, xinc_r, yinc_r;
  color_t color_r;
  thick_t thick_r, pass_r, pass_nxt;
  walk_t  walk_x_r, walk_y_r, err_x_r, err_y_r, step_r;
  walk_t  walk_x_nxt, walk_y_nxt, err_x_nxt, err_y_nxt, step_nxt;
  logic   load_line;

  // start-side decode
  logic   rej;
  coord_t in_adx, in_ady;

  // tick-side
  walk_t              sum_x, sum_y, dist_w, off;
  walk_t              sx0, sx1, sy0, sy1;
  logic [THICK_BITS:0] next_p;
  logic               pass_done, fits, more;

  assign rej = (x_start > screen.width) || (y_start > screen.height) ||
               (x_end > screen.width) || (y_end > screen.height) ||
               (COORD_BITS'(thickness) > screen.width);
  assign in_adx = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
  assign in_ady = (y_end >= y_start) ? y_end - y_start : y_start - y_end;

  assign dist_w = {1'b0, dist_r};
  assign sum_x  = err_x_r + {1'b0, adx_r};
  assign sum_y  = err_y_r + {1'b0, ady_r};
  assign next_p = {1'b0, pass_r} + (THICK_BITS+1)'(1);
  assign off    = WALK_BITS'(next_p);
  assign sx0    = {1'b0, x0_r} + (shx_r ? off : '0);
  assign sx1    = {1'b0, x1_r} + (shx_r ? off : '0);
  assign sy0    = {1'b0, y0_r} + (shx_r ? '0 : off);
  assign sy1    = {1'b0, y1_r} + (shx_r ? '0 : off);
  assign fits   = (sx0 <= {1'b0, screen.width}) && (sx1 <= {1'b0, screen.width}) &&
                  (sy0 <= {1'b0, screen.height}) && (sy1 <= {1'b0, screen.height});
  assign pass_done = step_r >= (dist_w + WALK_BITS'(1));
  assign more      = (next_p < {1'b0, thick_r}) && fits;

  always_comb begin
    busy_nxt   = busy_r;
    pass_nxt   = pass_r;
    walk_x_nxt = walk_x_r;
    walk_y_nxt = walk_y_r;
    err_x_nxt  = err_x_r;
    err_y_nxt  = err_y_r;
    step_nxt   = step_r;
    load_line  = 1'b0;
    res        = '0;
    if (!req_type) begin
      busy_nxt = 1'b0;
      if (rej) begin
        res.kind = KIND_REJECTED;
      end else begin
        res.kind   = KIND_ACCEPTED;
        load_line  = 1'b1;
        busy_nxt   = thickness != '0;
        pass_nxt   = '0;
        walk_x_nxt = {1'b0, x_start};
        walk_y_nxt = {1'b0, y_start};
        err_x_nxt  = '0;
        err_y_nxt  = '0;
        step_nxt   = '0;
      end
    end else if (!busy_r) begin
      res.kind = KIND_IDLE;
    end else begin
      res.kind  = KIND_PIXEL;
      res.px    = walk_x_r[COORD_BITS-1:0];
      res.py    = walk_y_r[COORD_BITS-1:0];
      res.color = color_r;
      err_x_nxt = sum_x;
      err_y_nxt = sum_y;
      if (sum_x > dist_w) begin
        err_x_nxt  = sum_x - dist_w;
        walk_x_nxt = xinc_r ? walk_x_r + WALK_BITS'(1) : walk_x_r - WALK_BITS'(1);
      end
      if (sum_y > dist_w) begin
        err_y_nxt  = sum_y - dist_w;
        walk_y_nxt = yinc_r ? walk_y_r + WALK_BITS'(1) : walk_y_r - WALK_BITS'(1);
      end
      if (pass_done) begin
        if (more) begin
          pass_nxt   = next_p[THICK_BITS-1:0];
          walk_x_nxt = sx0;
          walk_y_nxt = sy0;
          err_x_nxt  = '0;
          err_y_nxt  = '0;
          step_nxt   = '0;
        end else begin
          busy_nxt = 1'b0;
          res.last = 1'b1;
        end
      end else begin
        step_nxt = step_r + WALK_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (fire) begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pass_r   <= pass_nxt;
      walk_x_r <= walk_x_nxt;
      walk_y_r <= walk_y_nxt;
      err_x_r  <= err_x_nxt;
      err_y_r  <= err_y_nxt;
      step_r   <= step_nxt;
      if (load_line) begin
        x0_r    <= x_start;
        y0_r    <= y_start;
        x1_r    <= x_end;
        y1_r    <= y_end;
        adx_r   <= in_adx;
        ady_r   <= in_ady;
        dist_r  <= (in_adx > in_ady) ? in_adx : in_ady;
        shx_r   <= (x_start == x_end) && (y_start != y_end);
        xinc_r  <= x_end > x_start;
        yinc_r  <= y_end > y_start;
        color_r <= pen_color;
        thick_r <= thickness;
      end
    end
  end

  a_start_clears_or_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !req_type && rej |=> !busy_r)
    else $error("busy left set after a rejected start");

  a_err_x_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> err_x_r <= dist_w)
    else $error("x error accumulator exceeds distance");

  a_err_y_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> err_y_r <= dist_w)
    else $error("y error accumulator exceeds distance");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= dist_w + WALK_BITS'(1))
    else $error("step count past end of pass");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.last |=> !busy_r)
    else $error("still busy after last pixel");

endmodule

[rtl/thick_line_rasterizer_unit.sv]
// Thick line rasteriser top level: config registers, step core, result register.
// A result is presented in the cycle after its item is accepted.
// Throughput: one item per cycle; the whole step is one pass of core logic
// into the result register, and input is taken whenever that register is
// empty or is being drained in the same cycle.
// Reset (rst_n low, synchronous): idle, no result pending, screen 240 x 320.
module thick_line_rasterizer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  tlr_pkg::coord_t                  in_x_start,
  input  tlr_pkg::coord_t                  in_y_start,
  input  tlr_pkg::coord_t                  in_x_end,
  input  tlr_pkg::coord_t                  in_y_end,
  input  tlr_pkg::thick_t                  in_thickness,
  input  tlr_pkg::color_t                  in_pen_color,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_result_kind,
  output tlr_pkg::coord_t                  out_pixel_x,
  output tlr_pkg::coord_t                  out_pixel_y,
  output tlr_pkg::color_t                  out_pixel_color,
  output logic                             out_is_last,
  input  logic                             cfg_wr_en,
  input  logic [tlr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  tlr_pkg::coord_t                  cfg_wdata
);
  import tlr_pkg::*;

  screen_t screen;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    fire;

  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;

  tlr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .screen   (screen)
  );

  tlr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .req_type  (in_req_type),
    .x_start   (in_x_start),
    .y_start   (in_y_start),
    .x_end     (in_x_end),
    .y_end     (in_y_end),
    .thickness (in_thickness),
    .pen_color (in_pen_color),
    .screen    (screen),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = res_r.kind;
  assign out_pixel_x     = res_r.px;
  assign out_pixel_y     = res_r.py;
  assign out_pixel_color = res_r.color;
  assign out_is_last     = res_r.last;

endmodule

[tb/tlr_tb_pkg.sv]
// Request codes for the rasteriser's input channel, shared by the testbench files.
package tlr_tb_pkg;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_t;

endpackage

[tb/tlr_pixel_check.sv]
// Line walk predictor and result comparator for the thick line rasteriser.
module tlr_pixel_check
  import tlr_pkg::*;
  import tlr_tb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_req_type,
  input  coord_t                   in_x_start,
  input  coord_t                   in_y_start,
  input  coord_t                   in_x_end,
  input  coord_t                   in_y_end,
  input  thick_t                   in_thickness,
  input  color_t                   in_pen_color,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [1:0]               out_result_kind,
  input  coord_t                   out_pixel_x,
  input  coord_t                   out_pixel_y,
  input  color_t                   out_pixel_color,
  input  logic                     out_is_last,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  coord_t                   cfg_wdata,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WALK_MASK = (1 << WALK_BITS) - 1;

  coord_t      scr_w, scr_h;
  logic        drawing;
  coord_t      ln_x0, ln_y0, ln_x1, ln_y1;
  color_t      ln_color;
  thick_t      ln_thick, pass_no;
  int unsigned cur_x, cur_y, acc_x, acc_y, steps;
  result_t     pixel_q[$];
  int          mismatches = 0;
  int          queue_depth = 0;

  assign fail_count = mismatches;
  assign pending    = queue_depth;

  // vertical lines are thickened along x, everything else along y
  function automatic logic vertical_line();
    return ln_x0 == ln_x1 && ln_y0 != ln_y1;
  endfunction

  function automatic logic pass_on_screen(int unsigned p);
    int unsigned xs, ys, xe, ye;
    xs = ln_x0;
    ys = ln_y0;
    xe = ln_x1;
    ye = ln_y1;
    if (vertical_line()) begin
      xs += p;
      xe += p;
    end else begin
      ys += p;
      ye += p;
    end
    return xs <= scr_w && xe <= scr_w && ys <= scr_h && ye <= scr_h;
  endfunction

  function automatic void begin_pass(int unsigned p);
    pass_no = thick_t'(p);
    cur_x = ln_x0;
    cur_y = ln_y0;
    if (vertical_line()) cur_x += p;
    else cur_y += p;
    cur_x &= WALK_MASK;
    cur_y &= WALK_MASK;
    acc_x = 0;
    acc_y = 0;
    steps = 0;
  endfunction

  function automatic result_t raster_step(logic req, coord_t xs, coord_t ys, coord_t xe,
                                          coord_t ye, thick_t th, color_t col);
    result_t     r;
    int unsigned adx, ady, span;
    r = '0;
    if (req == REQ_START) begin
      drawing = 1'b0;
      if (xs > scr_w || ys > scr_h || xe > scr_w || ye > scr_h || th > scr_w) begin
        r.kind = KIND_REJECTED;
        return r;
      end
      ln_x0 = xs;
      ln_y0 = ys;
      ln_x1 = xe;
      ln_y1 = ye;
      ln_color = col;
      ln_thick = th;
      begin_pass(0);
      drawing = th != 0;
      r.kind = KIND_ACCEPTED;
      return r;
    end
    if (!drawing) begin
      r.kind = KIND_IDLE;
      return r;
    end
    adx = (ln_x1 >= ln_x0) ? ln_x1 - ln_x0 : ln_x0 - ln_x1;
    ady = (ln_y1 >= ln_y0) ? ln_y1 - ln_y0 : ln_y0 - ln_y1;
    span = (adx > ady) ? adx : ady;
    r.kind  = KIND_PIXEL;
    r.px    = coord_t'(cur_x);
    r.py    = coord_t'(cur_y);
    r.color = ln_color;
    acc_x += adx;
    acc_y += ady;
    if (acc_x > span) begin
      acc_x -= span;
      cur_x = ((ln_x1 > ln_x0) ? cur_x + 1 : cur_x - 1) & WALK_MASK;
    end
    if (acc_y > span) begin
      acc_y -= span;
      cur_y = ((ln_y1 > ln_y0) ? cur_y + 1 : cur_y - 1) & WALK_MASK;
    end
    if (steps >= span + 1) begin
      if (int'(pass_no) + 1 < int'(ln_thick) && pass_on_screen(int'(pass_no) + 1)) begin
        begin_pass(int'(pass_no) + 1);
      end else begin
        drawing = 1'b0;
        r.last = 1'b1;
      end
    end else begin
      steps++;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      scr_w = WIDTH_RESET;
      scr_h = HEIGHT_RESET;
      drawing = 1'b0;
      ln_x0 = '0;
      ln_y0 = '0;
      ln_x1 = '0;
      ln_y1 = '0;
      ln_color = '0;
      ln_thick = '0;
      pass_no = '0;
      cur_x = 0;
      cur_y = 0;
      acc_x = 0;
      acc_y = 0;
      steps = 0;
      pixel_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SCREEN_WIDTH:  scr_w = cfg_wdata;
          CFG_SCREEN_HEIGHT: scr_h = cfg_wdata;
          default: ;
        endcase
      end
      // results leave before the item taken on this edge is predicted
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $error("result with no item outstanding: kind %0d", out_result_kind);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("pixel_x", want.px, out_pixel_x);
          check_field("pixel_y", want.py, out_pixel_y);
          check_field("pixel_color", want.color, out_pixel_color);
          check_field("is_last", want.last, out_is_last);
        end
      end
      if (in_valid && !in_stall) begin
        pixel_q.push_back(raster_step(in_req_type, in_x_start, in_y_start, in_x_end,
                                      in_y_end, in_thickness, in_pen_color));
      end
    end
    queue_depth = pixel_q.size();
  end

endmodule

[tb/tb_thick_line_rasterizer_unit.sv]
// Testbench top for the thick line rasteriser: stimulus, flow control and verdict.
module tb_thick_line_rasterizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tlr_pkg::*;
  import tlr_tb_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_req_type;
  coord_t                  in_x_start, in_y_start, in_x_end, in_y_end;
  thick_t                  in_thickness;
  color_t                  in_pen_color;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_result_kind;
  coord_t                  out_pixel_x, out_pixel_y;
  color_t                  out_pixel_color;
  logic                    out_is_last;
  logic                    cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  coord_t                  cfg_wdata;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int scr_w = 240;
  int scr_h = 320;

  always #2 clk = ~clk;

  thick_line_rasterizer_unit uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_x_start, .in_y_start, .in_x_end, .in_y_end,
    .in_thickness, .in_pen_color,
    .out_valid, .out_stall, .out_result_kind, .out_pixel_x, .out_pixel_y,
    .out_pixel_color, .out_is_last,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  tlr_pixel_check pixel_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_x_start, .in_y_start, .in_x_end, .in_y_end,
    .in_thickness, .in_pen_color,
    .out_valid, .out_stall, .out_result_kind, .out_pixel_x, .out_pixel_y,
    .out_pixel_color, .out_is_last,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .fail_count, .pending
  );

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int n = 0; n < 64; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // entered and left just after a rising edge; in_valid stays high on return
  task automatic send_item(input logic req, input coord_t xs, input coord_t ys,
                           input coord_t xe, input coord_t ye, input thick_t th,
                           input color_t col);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_x_start   <= xs;
    in_y_start   <= ys;
    in_x_end     <= xe;
    in_y_end     <= ye;
    in_thickness <= th;
    in_pen_color <= col;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    items_sent++;
  endtask

  // payload of a tick is ignored, so it is random
  task automatic tick();
    send_item(REQ_TICK, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), thick_t'($urandom), color_t'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_screen(input int w, input int h);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_wdata <= coord_t'(w);
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= coord_t'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scr_w = w;
    scr_h = h;
  endtask

  function automatic int pick_coord(int limit);
    if ($urandom_range(9) == 0) return $urandom_range(1023);
    return $urandom_range(limit);
  endfunction

  function automatic int near_coord(int c, int limit);
    int v;
    v = c + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > limit) v = limit;
    return v;
  endfunction

  function automatic int pick_thickness();
    case ($urandom_range(19))
      0:       return 255;
      1, 2:    return $urandom_range(255);
      3, 4:    return $urandom_range(scr_w < 255 ? scr_w : 255);
      default: return $urandom_range(4);
    endcase
  endfunction

  // a start followed by about as many ticks as the line needs, sometimes cut short
  task automatic random_line();
    int x0, y0, x1, y1, th, dx, dy, est, n;
    x0 = pick_coord(scr_w);
    y0 = pick_coord(scr_h);
    if ($urandom_range(29) == 0) begin
      x1 = pick_coord(scr_w);
      y1 = pick_coord(scr_h);
    end else begin
      x1 = near_coord(x0, scr_w);
      y1 = near_coord(y0, scr_h);
    end
    case ($urandom_range(7))
      0: x1 = x0;
      1: y1 = y0;
      2: begin
        x1 = x0;
        y1 = y0;
      end
      default: ;
    endcase
    th = pick_thickness();
    dx = x1 > x0 ? x1 - x0 : x0 - x1;
    dy = y1 > y0 ? y1 - y0 : y0 - y1;
    est = ((dx > dy ? dx : dy) + 2) * (th == 0 ? 1 : th);
    if (est > 300) est = 300;
    case ($urandom_range(9))
      0:       n = 0;
      1, 2:    n = $urandom_range(est);
      default: n = est + $urandom_range(2);
    endcase
    send_item(REQ_START, coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1),
              thick_t'(th), color_t'($urandom));
    repeat (n) tick();
  endtask

  initial begin
    int target;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_TICK;
    in_x_start   = '0;
    in_y_start   = '0;
    in_x_end     = '0;
    in_y_end     = '0;
    in_thickness = '0;
    in_pen_color = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_SCREEN_WIDTH;
    cfg_wdata    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, on the reset screen size
    tick();
    send_item(REQ_START, 241, 0, 0, 0, 1, 16'hffff);
    send_item(REQ_START, 0, 0, 0, 0, 241, 16'hffff);
    send_item(REQ_START, 240, 320, 240, 320, 0, 16'h0000);
    tick();
    // vertical on the right edge: second pass falls off screen
    send_item(REQ_START, 240, 0, 240, 1, 2, 16'hffff);
    repeat (3) tick();
    send_item(REQ_START, 3, 2, 0, 0, 3, 16'h1234);
    repeat (2) tick();
    // abandons the diagonal; single point drawn twice
    send_item(REQ_START, 0, 0, 0, 0, 2, 16'h8001);
    repeat (5) tick();
    send_item(REQ_START, 0, 0, 1, 0, 1, 16'h00ff);
    tick();
    send_item(REQ_START, 0, 1023, 0, 0, 1, 16'h0000);
    tick();
    drain();

    target = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct = 11;
          stall_pct = 45;
        end
        1: begin
          idle_pct = 45;
          stall_pct = 11;
        end
        default: begin
          idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      for (int sub = 0; sub < 4; sub++) begin
        drain();
        case (sub)
          0:       set_screen(1023, 1023);
          1:       set_screen(1, 1);
          2:       set_screen($urandom_range(40, 2), $urandom_range(40, 2));
          default: set_screen($urandom_range(1023, 1), $urandom_range(1023, 1));
        endcase
        if (phase == 2 && sub == 0) hold_req = 1'b1;
        target += 125;
        while (items_sent < target) random_line();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("PASS thick_line_rasterizer_unit");
    else $display("FAIL thick_line_rasterizer_unit");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL thick_line_rasterizer_unit");
    $finish;
  end

endmodule

[files.f]
rtl/tlr_pkg.sv
rtl/tlr_cfg.sv
rtl/tlr_core.sv
rtl/thick_line_rasterizer_unit.sv
tb/tlr_tb_pkg.sv
tb/tlr_pixel_check.sv
tb/tb_thick_line_rasterizer_unit.sv
